### rtl/stpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the SCSI target phase controller.
// Used by the front, the back and the top level; depends on nothing.
package stpc_pkg;

  localparam int SECTOR_BYTES  = 2048;
  localparam int COMMAND_DEPTH = 16;
  localparam int SECT_AW       = $clog2(SECTOR_BYTES);
  localparam int CMD_AW        = $clog2(COMMAND_DEPTH);

  localparam logic [23:0] PERIOD_RESET = 24'd122880;
  localparam logic [7:0]  CMD_TEST     = 8'h00;
  localparam logic [7:0]  CMD_READ     = 8'h08;
  localparam logic [7:0]  CMD_IGNORE   = 8'hff;
  localparam logic [7:0]  STAT_GOOD    = 8'h00;
  localparam logic [7:0]  STAT_CHECK   = 8'h01;
  localparam logic [7:0]  MSG_COMPLETE = 8'h00;

  localparam logic CFG_DISC   = 1'b0;
  localparam logic CFG_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    OP_BUS_WRITE = 2'd0,
    OP_HOST_READ = 2'd1,
    OP_TICK      = 2'd2,
    OP_LOAD      = 2'd3
  } op_t;

  // One decoded input item as handed from the front to the back.
  typedef struct packed {
    op_t         op;
    logic        sel;
    logic        ack;
    logic        rst;
    logic [7:0]  host_byte;
    logic [7:0]  sector_byte;
    logic [10:0] byte_index;
    logic        byte_last;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        busy;
    logic        req;
    logic        msg;
    logic        cd;
    logic        io;
    logic [7:0]  data;
    logic        irq_ready;
    logic        irq_done;
    logic        fetch_valid;
    logic [23:0] fetch_lba;
  } result_t;

endpackage

### rtl/stpc_front.sv
`timescale 1ns / 1ps
// Front end: two-entry input queue that accepts and classifies items.
// Depends on stpc_pkg.
module stpc_front import stpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_operation,
  input  logic        in_bus_select,
  input  logic        in_bus_ack,
  input  logic        in_bus_reset,
  input  logic [7:0]  in_host_byte,
  input  logic [7:0]  in_sector_byte,
  input  logic [10:0] in_byte_index,
  input  logic        in_byte_last,
  output logic        item_valid,
  output item_t       item,
  input  logic        item_take
);

  item_t       q_r [2];
  logic        head_r, head_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       dec;
  logic        wr, rd;

  // Classify the incoming transfer.
  always_comb begin
    dec             = '0;
    dec.op          = op_t'(in_operation);
    dec.sel         = in_bus_select;
    dec.ack         = in_bus_ack;
    dec.rst         = in_bus_reset;
    dec.host_byte   = in_host_byte;
    dec.sector_byte = in_sector_byte;
    dec.byte_index  = in_byte_index;
    dec.byte_last   = in_byte_last;
  end

  assign full       = (cnt_r == 2'd2);
  assign wr         = push && !full;
  assign item_valid = (cnt_r != 2'd0);
  assign rd         = item_valid && item_take;
  assign item       = q_r[head_r];

  always_comb begin
    head_nxt = rd ? ~head_r : head_r;
    cnt_nxt  = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[head_r ^ cnt_r[0]] <= dec;
    end
  end

endmodule

### rtl/stpc_back.sv
`timescale 1ns / 1ps
// Back end: phase state machine, sector buffer and two-entry result queue.
// Depends on stpc_pkg.
module stpc_back import stpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        item_valid,
  input  item_t       item,
  output logic        item_take,
  output logic        empty,
  input  logic        pop,
  output result_t     res
);

  typedef struct packed {
    logic busy, req, msg, cd, io, sel, selected, was_reset;
    logic msg_sent, status_sent, msg_after, transferred;
    logic                                ack;
    logic                                rstl;
    logic [7:0]                          data;
    logic                                irq_ready;
    logic                                irq_done;
    logic                                pending;
    logic [23:0]                         tick;
    logic [23:0]                         lba;
    logic [24:0]                         rend;
    logic [SECT_AW:0]                    pos;
    logic [SECT_AW:0]                    len;
    logic [CMD_AW:0]                     ccnt;
    logic [COMMAND_DEPTH-1:0][7:0]       cmd;
  } st_t;

  st_t         s_r, s_nxt;
  logic        disc_r;
  logic [23:0] period_r;
  logic [7:0]  shown;

  logic [7:0]  mem [SECTOR_BYTES];
  logic [7:0]  mem_q_r, byp_d_r, rdb;
  logic        byp_r, mem_we;
  logic [SECT_AW-1:0] raddr;

  result_t     q_r [2];
  logic        head_r;
  logic [1:0]  cnt_r;
  logic        oq_rd;
  result_t     r_new;

  function automatic st_t reply(st_t s, logic [7:0] code);
    st_t t;
    t = s;
    t.req = 1'b1; t.msg = 1'b0; t.cd = 1'b1; t.io = 1'b1;
    t.msg_after = 1'b1; t.msg_sent = 1'b0; t.status_sent = 1'b0;
    t.data = code;
    return t;
  endfunction

  // One pass of the bus phase update.
  function automatic st_t phase_update(st_t s_in, logic [7:0] rb, logic disc);
    st_t s;
    s = s_in;
    if (!s.was_reset && s.rstl) begin
      s.busy = 1'b0; s.req = 1'b0; s.msg = 1'b0;
      s.cd = 1'b0; s.io = 1'b0; s.sel = 1'b0;
    end
    s.was_reset = s.rstl;
    if (!s.busy && !s.sel && s.selected) begin
      s.selected = 1'b0; s.req = 1'b0; s.msg = 1'b0;
      s.cd = 1'b0; s.io = 1'b0; s.irq_done = 1'b0;
    end
    if (!s.selected && s.sel) begin
      s.selected = 1'b1; s.busy = 1'b1; s.req = 1'b1;
      s.msg = 1'b0; s.cd = 1'b1; s.io = 1'b0;
    end
    if (s.busy) begin
      if (s.msg) begin
        if (s.io) begin
          // Message-in phase.
          if (s.req && s.ack) begin
            s.req = 1'b0; s.msg_sent = 1'b1;
          end
          if (!s.req && !s.ack && s.msg_sent) begin
            s.busy = 1'b0; s.msg_sent = 1'b0;
          end
        end else if (s.req && s.ack) begin
          s.req = 1'b0;
        end
      end else if (s.io) begin
        if (s.cd) begin
          // Status phase.
          if (s.req && s.ack) begin
            s.req = 1'b0; s.status_sent = 1'b1;
          end
          if (!s.req && !s.ack && s.status_sent) begin
            s.status_sent = 1'b0;
            if (s.msg_after) begin
              s.msg_after = 1'b0;
              s.req = 1'b1; s.msg = 1'b1; s.data = MSG_COMPLETE;
            end
          end
        end else begin
          // Data-in phase.
          if (s.req && s.ack) s.req = 1'b0;
          if (!s.req && !s.ack) begin
            if (s.pos >= s.len) begin
              s.irq_ready = 1'b0;
              if (s.transferred) begin
                s.transferred = 1'b0;
                s = reply(s, STAT_GOOD);
                s.irq_done = 1'b1;
              end
            end else begin
              s.data = rb;
              s.pos  = s.pos + 1'b1;
              s.req  = 1'b1;
            end
          end
        end
      end else begin
        // Command phase.
        if (s.req && s.ack) begin
          s.req = 1'b0;
          if (s.ccnt < (CMD_AW+1)'(COMMAND_DEPTH)) begin
            s.cmd[s.ccnt[CMD_AW-1:0]] = s.data;
            s.ccnt = s.ccnt + 1'b1;
          end
        end
        if (!s.req && !s.ack && s.ccnt != '0) begin
          if ((s.cmd[0] == CMD_TEST && s.ccnt == (CMD_AW+1)'(6)) ||
              (s.cmd[0] == CMD_IGNORE && s.ccnt == (CMD_AW+1)'(1))) begin
            s = reply(s, STAT_GOOD);
            s.ccnt = '0;
          end else if (s.cmd[0] == CMD_READ && s.ccnt == (CMD_AW+1)'(6)) begin
            s.ccnt = '0;
            if (!disc) begin
              s = reply(s, STAT_CHECK);
            end else if (s.cmd[4] == 8'h00) begin
              s = reply(s, STAT_GOOD);
            end else begin
              s.lba       = {s.cmd[1], s.cmd[2], s.cmd[3]};
              s.rend      = {1'b0, s.lba} + {17'd0, s.cmd[4]};
              s.pending   = 1'b0;
              s.irq_ready = 1'b1;
            end
          end else begin
            s.req = 1'b1;
          end
        end
      end
    end
    return s;
  endfunction

  // Sector byte at the current buffer position, with write bypass.
  assign rdb = byp_r ? byp_d_r : mem_q_r;

  assign item_take = item_valid && ((cnt_r != 2'd2) || pop);

  // Next state for one item.
  always_comb begin
    logic [24:0] nx;
    s_nxt  = s_r;
    shown  = s_r.data;
    mem_we = 1'b0;
    nx     = '0;
    if (item_take) begin
      case (item.op)
        OP_BUS_WRITE: begin
          s_nxt.sel  = item.sel;
          s_nxt.ack  = item.ack;
          s_nxt.rstl = item.rst;
          s_nxt.data = item.host_byte;
          s_nxt      = phase_update(s_nxt, rdb, disc_r);
          shown      = s_nxt.data;
        end
        OP_HOST_READ: begin
          if (s_r.req && !s_r.ack && !s_r.cd && s_r.io) begin
            s_nxt.ack = 1'b1;
            s_nxt     = phase_update(s_nxt, rdb, disc_r);
            s_nxt.ack = 1'b0;
            s_nxt     = phase_update(s_nxt, rdb, disc_r);
          end
        end
        OP_TICK: begin
          s_nxt.tick = s_r.tick + 1'b1;
          if (s_nxt.tick >= period_r) begin
            s_nxt.tick = '0;
            if ({1'b0, s_r.lba} < s_r.rend && s_r.pos == s_r.len && !s_r.pending) begin
              s_nxt.pending = 1'b1;
            end
          end
        end
        default: begin
          if (s_r.pending) begin
            mem_we = 1'b1;
            if (item.byte_last) begin
              nx            = {1'b0, s_r.lba} + 25'd1;
              s_nxt.pending = 1'b0;
              if (nx >= s_r.rend || nx[24]) begin
                s_nxt.transferred = 1'b1;
                s_nxt.lba         = nx[23:0];
                s_nxt.rend        = {1'b0, nx[23:0]};
              end else begin
                s_nxt.transferred = 1'b0;
                s_nxt.lba         = nx[23:0];
              end
              s_nxt.cd  = 1'b0;
              s_nxt.io  = 1'b1;
              s_nxt.pos = '0;
              s_nxt.len = (SECT_AW+1)'(SECTOR_BYTES);
            end
          end
        end
      endcase
    end
  end

  assign raddr = s_nxt.pos[SECT_AW-1:0];

  // Build the result item.
  always_comb begin
    r_new             = '0;
    r_new.busy        = s_nxt.busy;
    r_new.req         = s_nxt.req;
    r_new.msg         = s_nxt.msg;
    r_new.cd          = s_nxt.cd;
    r_new.io          = s_nxt.io;
    r_new.data        = shown;
    r_new.irq_ready   = s_nxt.irq_ready;
    r_new.irq_done    = s_nxt.irq_done;
    r_new.fetch_valid = s_nxt.pending;
    r_new.fetch_lba   = s_nxt.pending ? s_nxt.lba : 24'd0;
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r      <= '0;
      disc_r   <= 1'b0;
      period_r <= PERIOD_RESET;
    end else begin
      s_r <= s_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DISC:   disc_r   <= cfg_data[0];
          default:    period_r <= cfg_data;
        endcase
      end
    end
  end

  // Sector buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[item.byte_index[SECT_AW-1:0]] <= item.sector_byte;
    end
    mem_q_r <= mem[raddr];
    byp_r   <= mem_we && (item.byte_index[SECT_AW-1:0] == raddr);
    byp_d_r <= item.sector_byte;
  end

  // Result queue.
  assign empty = (cnt_r == 2'd0);
  assign oq_rd = pop && !empty;
  assign res   = q_r[head_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= oq_rd ? ~head_r : head_r;
      cnt_r  <= cnt_r + {1'b0, item_take} - {1'b0, oq_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      q_r[head_r ^ cnt_r[0]] <= r_new;
    end
  end

endmodule

### rtl/scsi_target_phase_controller.sv
`timescale 1ns / 1ps
// Top level of the SCSI target phase controller.
// Depends on stpc_pkg, stpc_front and stpc_back.
//
//  channel  | handshake        | payload
//  ---------+------------------+----------------------------------------
//  input    | push / full      | in_operation .. in_byte_last
//  result   | empty / pop      | out_bus_busy .. out_fetch_lba
//  config   | cfg_we           | cfg_index, cfg_data
//
// One item per clock sustained while the result queue has room or is popped;
// every item yields one result. An item is registered in the input queue, is
// executed in the back end when taken and its result is registered in the result queue.
// Reset is synchronous, active low, and needs no clearing pass.
// A full result queue stalls the back end, which in turn fills the input queue.
module scsi_target_phase_controller import stpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_operation,
  input  logic        in_bus_select,
  input  logic        in_bus_ack,
  input  logic        in_bus_reset,
  input  logic [7:0]  in_host_byte,
  input  logic [7:0]  in_sector_byte,
  input  logic [10:0] in_byte_index,
  input  logic        in_byte_last,
  output logic        empty,
  input  logic        pop,
  output logic        out_bus_busy,
  output logic        out_bus_req,
  output logic        out_bus_msg,
  output logic        out_bus_cd,
  output logic        out_bus_io,
  output logic [7:0]  out_bus_data,
  output logic        out_irq_ready,
  output logic        out_irq_done,
  output logic        out_fetch_valid,
  output logic [23:0] out_fetch_lba
);

  logic    item_valid, item_take;
  item_t   item;
  result_t res;

  stpc_front u_front (
    .clk, .rst_n, .push, .full,
    .in_operation, .in_bus_select, .in_bus_ack, .in_bus_reset,
    .in_host_byte, .in_sector_byte, .in_byte_index, .in_byte_last,
    .item_valid, .item, .item_take
  );

  stpc_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .item_valid, .item, .item_take, .empty, .pop, .res
  );

  assign out_bus_busy    = res.busy;
  assign out_bus_req     = res.req;
  assign out_bus_msg     = res.msg;
  assign out_bus_cd      = res.cd;
  assign out_bus_io      = res.io;
  assign out_bus_data    = res.data;
  assign out_irq_ready   = res.irq_ready;
  assign out_irq_done    = res.irq_done;
  assign out_fetch_valid = res.fetch_valid;
  assign out_fetch_lba   = res.fetch_lba;

  // A shown address always belongs to an outstanding fetch.
  a_lba_needs_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_fetch_valid) |-> (out_fetch_lba == 24'd0))
    else $error("fetch address shown without outstanding fetch");

  // An item taken by the back end shows as a waiting result on the next cycle.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && item_take) |=> !empty)
    else $error("executed item produced no result");

  // The back end never takes an item the front end does not hold.
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |-> item_valid)
    else $error("back end took from an empty input queue");

endmodule
